FILE: hdl/hnu_pkg.sv
// ----------------------------------------------------------------------------
// hnu_pkg
// Shared constants, codes and types of the Hopfield neuron update core.
// ----------------------------------------------------------------------------
package hnu_pkg;

	localparam int NEURONS_DEF       = 1024;
	localparam int COUPLING_BITS_DEF = 4;

	localparam int TYPE_W   = 2;
	localparam int INDEX_W  = 10;
	localparam int CVAL_W   = 4;
	localparam int NOISE_W  = 7;
	localparam int GAIN_W   = 16;
	localparam int COUNT_W  = 11;
	localparam int ACT_W    = 16;
	localparam int CFG_IW   = 2;
	localparam int CFG_DW   = 16;

	typedef enum logic [TYPE_W-1:0] {
		REQ_WR_COUPLING = 2'd0,
		REQ_WR_BIT      = 2'd1,
		REQ_UPDATE      = 2'd2,
		REQ_RD_BIT      = 2'd3
	} req_kind_t;

	localparam logic [CFG_IW-1:0] REG_ACT_GAIN   = 2'd0;
	localparam logic [CFG_IW-1:0] REG_THR_GAIN   = 2'd1;
	localparam logic [CFG_IW-1:0] REG_NOISE_GAIN = 2'd2;
	localparam logic [CFG_IW-1:0] REG_COUNT      = 2'd3;

	localparam logic [GAIN_W-1:0]  ACT_GAIN_RST   = 16'd256;
	localparam logic [GAIN_W-1:0]  THR_GAIN_RST   = 16'd256;
	localparam logic [GAIN_W-1:0]  NOISE_GAIN_RST = 16'd0;
	localparam logic [COUNT_W-1:0] COUNT_RST      = 11'd1024;

	typedef struct packed {
		logic clear;
		logic add;
		logic mul;
		logic fin;
	} eval_ctl_t;

	typedef struct packed {
		logic              pos;
		logic              neg;
		logic [ACT_W-1:0]  act;
	} eval_res_t;

endpackage

FILE: hdl/hnu_req_if.sv
// ----------------------------------------------------------------------------
// hnu_req_if
// Request channel: valid/ready handshake carrying one request item.
// ----------------------------------------------------------------------------
interface hnu_req_if;

	logic                         valid;
	logic                         ready;
	logic [hnu_pkg::TYPE_W-1:0]   req_type;
	logic [hnu_pkg::INDEX_W-1:0]  neuron_index;
	logic [hnu_pkg::INDEX_W-1:0]  other_index;
	logic [hnu_pkg::CVAL_W-1:0]   coupling_value;
	logic                         bit_in;
	logic signed [hnu_pkg::NOISE_W-1:0] noise_step;

	modport source (
		output valid, req_type, neuron_index, other_index, coupling_value, bit_in,
		       noise_step,
		input  ready
	);

	modport sink (
		input  valid, req_type, neuron_index, other_index, coupling_value, bit_in,
		       noise_step,
		output ready
	);

endinterface

FILE: hdl/hnu_rsp_if.sv
// ----------------------------------------------------------------------------
// hnu_rsp_if
// Response channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface hnu_rsp_if;

	logic                               valid;
	logic                               ready;
	logic [hnu_pkg::INDEX_W-1:0]        result_index;
	logic                               bit_out;
	logic                               changed;
	logic signed [hnu_pkg::ACT_W-1:0]   activation;
	logic                               status;

	modport source (
		output valid, result_index, bit_out, changed, activation, status,
		input  ready
	);

	modport sink (
		input  valid, result_index, bit_out, changed, activation, status,
		output ready
	);

endinterface

FILE: hdl/hopfield_neuron_update_core.sv
// ----------------------------------------------------------------------------
// hopfield_neuron_update_core
// Binary Hopfield network neuron update over on-chip state and coupling memories.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel and each gives exactly one result on the
// rsp channel, in order. A request is taken only while the core is idle.
// Coupling writes, state writes and state reads reach rsp through the look-up
// and done states; a flagged request goes straight to the done state.
// An update sweeps the coupling row and the state memory one neuron per cycle
// through a single read port each, then passes through the drain, multiply,
// sum and decide states for the last read, the products, the decision and the
// write-back, and through the done state to load the result register; the
// sweep length dominates the throughput.
// The core returns to idle as the result register loads, so the next request
// is taken in the following cycle at the earliest, not before the last is done.
// If rsp stalls, a finished item holds in the core until the result register
// frees, and no new request is taken meanwhile.
// After reset the state memory is swept to zero, one entry per cycle, and
// req.ready stays low during that pass. Configuration writes
// are taken at any time and must only be issued while the core is idle.
// ----------------------------------------------------------------------------
module hopfield_neuron_update_core #(
	parameter int NEURONS       = hnu_pkg::NEURONS_DEF,
	parameter int COUPLING_BITS = hnu_pkg::COUPLING_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [hnu_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [hnu_pkg::CFG_DW-1:0]    cfg_data,
	hnu_req_if.sink                       req,
	hnu_rsp_if.source                     rsp
);

	localparam int AW  = $clog2(NEURONS);
	localparam int CAW = $clog2(NEURONS * NEURONS);
	localparam int CW  = (AW + 1 > hnu_pkg::COUNT_W) ? AW + 1 : hnu_pkg::COUNT_W;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_SWEEP,
		ST_DRAIN,
		ST_MUL,
		ST_SUM,
		ST_DEC,
		ST_DONE
	} state_t;

	// configuration registers
	logic signed [hnu_pkg::GAIN_W-1:0] act_gain_q;
	logic signed [hnu_pkg::GAIN_W-1:0] thr_gain_q;
	logic signed [hnu_pkg::GAIN_W-1:0] noise_gain_q;
	logic [hnu_pkg::COUNT_W-1:0]       count_q;

	// control
	state_t                        state_q;
	logic [AW-1:0]                 j_q;
	logic                          pend_s1;
	logic                          self_s1;
	logic                          old_q;
	logic                          res_bit_q;
	logic                          res_chg_q;
	logic [hnu_pkg::ACT_W-1:0]     res_act_q;
	logic                          res_st_q;
	logic                          out_valid_q;

	// request payload
	hnu_pkg::req_kind_t            kind_q;
	logic [hnu_pkg::INDEX_W-1:0]   ni_raw_q;
	logic [AW-1:0]                 ni_q;
	logic                          bin_q;
	logic signed [hnu_pkg::NOISE_W-1:0] noise_q;
	logic [CAW-1:0]                base_q;

	// result payload
	logic [hnu_pkg::INDEX_W-1:0]   out_index_q;
	logic                          out_bit_q;
	logic                          out_chg_q;
	logic [hnu_pkg::ACT_W-1:0]     out_act_q;
	logic                          out_st_q;

	// memories
	logic [COUPLING_BITS-1:0]      coup_mem [NEURONS * NEURONS];
	logic                          bits_mem [NEURONS];
	logic [COUPLING_BITS-1:0]      coup_rdata;
	logic                          bits_rdata;

	logic                          coup_we;
	logic [CAW-1:0]                coup_waddr;
	logic [CAW-1:0]                coup_raddr;
	logic                          bits_we;
	logic [AW-1:0]                 bits_waddr;
	logic                          bits_wdata;
	logic [AW-1:0]                 bits_raddr;

	logic                          accept;
	logic                          flag;
	hnu_pkg::req_kind_t            kind_in;
	logic [AW-1:0]                 ni_in;
	logic [AW-1:0]                 oi_in;
	logic [CW-1:0]                 cnt_eff;
	logic                          last_j;
	logic                          load_out;
	logic                          new_bit;

	hnu_pkg::eval_ctl_t            ev_ctl;
	hnu_pkg::eval_res_t            ev_res;
	logic [COUPLING_BITS-1:0]      ev_add;

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_gain_q   <= hnu_pkg::ACT_GAIN_RST;
			thr_gain_q   <= hnu_pkg::THR_GAIN_RST;
			noise_gain_q <= hnu_pkg::NOISE_GAIN_RST;
			count_q      <= hnu_pkg::COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				hnu_pkg::REG_ACT_GAIN:   act_gain_q   <= cfg_data;
				hnu_pkg::REG_THR_GAIN:   thr_gain_q   <= cfg_data;
				hnu_pkg::REG_NOISE_GAIN: noise_gain_q <= cfg_data;
				hnu_pkg::REG_COUNT:      count_q      <= cfg_data[hnu_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cnt_eff = (CW'(count_q) > CW'(NEURONS)) ? CW'(NEURONS) : CW'(count_q);

	assign kind_in = hnu_pkg::req_kind_t'(req.req_type);
	assign ni_in   = AW'(req.neuron_index);
	assign oi_in   = AW'(req.other_index);
	assign flag    = (CW'(req.neuron_index) >= cnt_eff) ||
	                 ((kind_in == hnu_pkg::REQ_WR_COUPLING) && (CW'(req.other_index) >= cnt_eff));

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign last_j    = (CW'(j_q) == cnt_eff - CW'(1));
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);
	assign new_bit   = ev_res.pos ? 1'b1 : (ev_res.neg ? 1'b0 : old_q);

	// memory port steering
	assign coup_we    = accept && !flag && (kind_in == hnu_pkg::REQ_WR_COUPLING);
	assign coup_waddr = CAW'(ni_in) * CAW'(NEURONS) + CAW'(oi_in);
	assign coup_raddr = base_q + CAW'(j_q);

	always_comb begin
		bits_we    = 1'b0;
		bits_waddr = j_q;
		bits_wdata = 1'b0;
		bits_raddr = j_q;
		case (state_q)
			ST_CLEAR: begin
				bits_we = 1'b1;
			end
			ST_IDLE: begin
				bits_raddr = ni_in;
				if (accept && !flag && (kind_in == hnu_pkg::REQ_WR_BIT)) begin
					bits_we    = 1'b1;
					bits_waddr = ni_in;
					bits_wdata = req.bit_in;
				end
			end
			ST_DEC: begin
				bits_we    = 1'b1;
				bits_waddr = ni_q;
				bits_wdata = new_bit;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (coup_we) begin
			coup_mem[coup_waddr] <= COUPLING_BITS'(req.coupling_value);
		end
		coup_rdata <= coup_mem[coup_raddr];
	end

	always_ff @(posedge clk) begin
		if (bits_we) begin
			bits_mem[bits_waddr] <= bits_wdata;
		end
		bits_rdata <= bits_mem[bits_raddr];
	end

	// accumulate and decide
	assign ev_ctl.clear = accept && (kind_in == hnu_pkg::REQ_UPDATE);
	assign ev_ctl.add   = pend_s1;
	assign ev_ctl.mul   = (state_q == ST_MUL);
	assign ev_ctl.fin   = (state_q == ST_SUM);
	assign ev_add       = (bits_rdata && !self_s1) ? coup_rdata : '0;

	hnu_eval #(
		.NEURONS       (NEURONS),
		.COUPLING_BITS (COUPLING_BITS)
	) u_eval (
		.clk        (clk),
		.ctl        (ev_ctl),
		.add_val    (ev_add),
		.act_gain   (act_gain_q),
		.thr_gain   (thr_gain_q),
		.noise_gain (noise_gain_q),
		.noise      (noise_q),
		.res        (ev_res)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			j_q         <= '0;
			pend_s1     <= 1'b0;
			self_s1     <= 1'b0;
			old_q       <= 1'b0;
			res_bit_q   <= 1'b0;
			res_chg_q   <= 1'b0;
			res_act_q   <= '0;
			res_st_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= (state_q == ST_SWEEP);
			self_s1 <= (j_q == ni_q);
			if (pend_s1 && self_s1) begin
				old_q <= bits_rdata;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					j_q <= j_q + AW'(1);
					if (j_q == AW'(NEURONS - 1)) begin
						j_q     <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						res_bit_q <= 1'b0;
						res_chg_q <= 1'b0;
						res_act_q <= '0;
						res_st_q  <= flag;
						j_q       <= '0;
						if (flag) begin
							state_q <= ST_DONE;
						end else if (kind_in == hnu_pkg::REQ_UPDATE) begin
							state_q <= ST_SWEEP;
						end else begin
							state_q <= ST_LOOK;
						end
					end
				end
				ST_LOOK: begin
					res_bit_q <= (kind_q == hnu_pkg::REQ_WR_BIT) ? bin_q : bits_rdata;
					state_q   <= ST_DONE;
				end
				ST_SWEEP: begin
					j_q <= j_q + AW'(1);
					if (last_j) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					res_bit_q <= new_bit;
					res_chg_q <= new_bit ^ old_q;
					res_act_q <= ev_res.act;
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= kind_in;
			ni_raw_q <= req.neuron_index;
			ni_q     <= ni_in;
			bin_q    <= req.bit_in;
			noise_q  <= req.noise_step;
			base_q   <= CAW'(ni_in) * CAW'(NEURONS);
		end
		if (load_out) begin
			out_index_q <= ni_raw_q;
			out_bit_q   <= res_bit_q;
			out_chg_q   <= res_chg_q;
			out_act_q   <= res_act_q;
			out_st_q    <= res_st_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_index = out_index_q;
	assign rsp.bit_out      = out_bit_q;
	assign rsp.changed      = out_chg_q;
	assign rsp.activation   = out_act_q;
	assign rsp.status       = out_st_q;

endmodule

FILE: hdl/hnu_eval.sv
// ----------------------------------------------------------------------------
// hnu_eval
// Activation accumulator and decision datapath: sums coupling terms, applies
// the gains in two registered steps and gives the sign of the decision value.
// ----------------------------------------------------------------------------
module hnu_eval #(
	parameter int NEURONS       = hnu_pkg::NEURONS_DEF,
	parameter int COUPLING_BITS = hnu_pkg::COUPLING_BITS_DEF
) (
	input  logic                                   clk,
	input  hnu_pkg::eval_ctl_t                     ctl,
	input  logic [COUPLING_BITS-1:0]               add_val,
	input  logic signed [hnu_pkg::GAIN_W-1:0]      act_gain,
	input  logic signed [hnu_pkg::GAIN_W-1:0]      thr_gain,
	input  logic signed [hnu_pkg::GAIN_W-1:0]      noise_gain,
	input  logic signed [hnu_pkg::NOISE_W-1:0]     noise,
	output hnu_pkg::eval_res_t                     res
);

	localparam int AW    = $clog2(NEURONS);
	localparam int SUM_W = AW + COUPLING_BITS;
	localparam int PW    = SUM_W + hnu_pkg::GAIN_W + 1;
	localparam int NPW   = hnu_pkg::GAIN_W + hnu_pkg::NOISE_W;
	localparam int DW    = (SUM_W + 19 > NPW + 2) ? SUM_W + 19 : NPW + 2;
	localparam int SXW   = ((SUM_W > hnu_pkg::ACT_W) ? SUM_W : hnu_pkg::ACT_W) + 2;

	logic [SUM_W-1:0]        sum_q;
	logic signed [PW-1:0]    prod_a_q;
	logic signed [NPW-1:0]   prod_n_q;
	logic signed [DW-1:0]    diff;
	logic [SXW-1:0]          sum_x;
	logic [SXW-1:0]          h_neg;
	logic [hnu_pkg::ACT_W-1:0] act_sat;
	hnu_pkg::eval_res_t      res_q;

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			sum_q <= '0;
		end else if (ctl.add) begin
			sum_q <= sum_q + SUM_W'(add_val);
		end
		if (ctl.mul) begin
			prod_a_q <= PW'(act_gain) * PW'($signed({1'b0, sum_q}));
			prod_n_q <= NPW'(noise_gain) * NPW'(noise);
		end
	end

	// diff = -2*ag*sum + 4*tg + ng*noise
	assign diff = DW'(prod_n_q) + (DW'(thr_gain) <<< 2) - (DW'(prod_a_q) <<< 1);

	// h = -2*sum is never positive, saturate below only
	assign sum_x   = SXW'(sum_q);
	assign h_neg   = SXW'(0) - (sum_x << 1);
	assign act_sat = (sum_x > SXW'(16384)) ? 16'h8000 : h_neg[hnu_pkg::ACT_W-1:0];

	always_ff @(posedge clk) begin
		if (ctl.fin) begin
			res_q.pos <= !diff[DW-1] && (diff != '0);
			res_q.neg <= diff[DW-1];
			res_q.act <= act_sat;
		end
	end

	assign res = res_q;

endmodule
